// ----- design/otp_awb_pkg.sv -----
// Package for the OTP white-balance gain calculator.
// Holds widths, reset values, status and register codes and the queue item type.
// No dependencies.
package otp_awb_pkg;

  localparam int unsigned RATIO_W    = 10;
  localparam int unsigned NUM1_W     = 20;  // typical ratio * 1000
  localparam int unsigned NUM2_W     = 30;  // scaled ratio * 0x400
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [9:0]  RATIO_SCALE = 10'd1000;
  localparam logic [15:0] UNITY_GAIN  = 16'h0400;

  localparam logic [9:0] RST_A_TYP_RG = 10'd327;
  localparam logic [9:0] RST_A_TYP_BG = 10'd288;
  localparam logic [9:0] RST_B_TYP_RG = 10'd308;
  localparam logic [9:0] RST_B_TYP_BG = 10'd302;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NO_GROUP       = 3'd1,
    ST_ZERO_RATIO     = 3'd2,
    ST_UNKNOWN_MODULE = 3'd3,
    ST_ZERO_BASE      = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ID     = 8'd0,
    REG_A_TYP_RG = 8'd1,
    REG_A_TYP_BG = 8'd2,
    REG_B_ID     = 8'd3,
    REG_B_TYP_RG = 8'd4,
    REG_B_TYP_BG = 8'd5
  } reg_idx_t;

  // classified item handed from front to back
  typedef struct packed {
    status_t              status;
    logic [NUM1_W-1:0]    num_rg;
    logic [NUM1_W-1:0]    num_bg;
    logic [RATIO_W-1:0]   rg;
    logic [RATIO_W-1:0]   bg;
  } item_t;

endpackage

// ----- design/otp_awb_if.sv -----
// Channel interfaces: calibration input, gain result and register writes.
// Depends on otp_awb_pkg.
interface otp_awb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] group_flag;
  logic [7:0] grp1_rg_high;
  logic [7:0] grp1_bg_high;
  logic [7:0] grp1_low_bits;
  logic [7:0] grp2_rg_high;
  logic [7:0] grp2_bg_high;
  logic [7:0] grp2_low_bits;
  logic [7:0] module_id;
  modport source (output valid, group_flag, grp1_rg_high, grp1_bg_high, grp1_low_bits,
                  grp2_rg_high, grp2_bg_high, grp2_low_bits, module_id, input ready);
  modport sink   (input valid, group_flag, grp1_rg_high, grp1_bg_high, grp1_low_bits,
                  grp2_rg_high, grp2_bg_high, grp2_low_bits, module_id, output ready);
endinterface

interface otp_awb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_gain;
  logic [15:0] green_gain;
  logic [15:0] blue_gain;
  logic        red_apply;
  logic        green_apply;
  logic        blue_apply;
  logic [2:0]  status;
  modport source (output valid, red_gain, green_gain, blue_gain, red_apply, green_apply,
                  blue_apply, status, input ready);
  modport sink   (input valid, red_gain, green_gain, blue_gain, red_apply, green_apply,
                  blue_apply, status, output ready);
endinterface

interface otp_awb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [otp_awb_pkg::CFG_IDX_W-1:0]  index;
  logic [otp_awb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/otp_awb_front.sv -----
// Front end: picks the valid group, rebuilds ratios, matches module ID.
// Registers one classified item. Depends on otp_awb_pkg and otp_awb_if.
module otp_awb_front (
  input  logic                      clk,
  input  logic                      rst_n,
  otp_awb_in_if.sink                in_ch,
  input  logic [7:0]                a_id,
  input  logic [9:0]                a_typ_rg,
  input  logic [9:0]                a_typ_bg,
  input  logic [7:0]                b_id,
  input  logic [9:0]                b_typ_rg,
  input  logic [9:0]                b_typ_bg,
  output logic                      item_valid,
  output otp_awb_pkg::item_t        item,
  input  logic                      item_ready
);
  import otp_awb_pkg::*;

  logic       vld_r;
  item_t      item_r, item_nxt;
  logic [7:0] rg_hi, bg_hi, lo;
  logic       grp_ok;
  logic [9:0] typ_rg, typ_bg;

  assign in_ch.ready = !vld_r || item_ready;
  assign item_valid  = vld_r;
  assign item        = item_r;

  always_comb begin
    grp_ok = 1'b1;
    if (in_ch.group_flag[7:6] == 2'b01) begin
      rg_hi = in_ch.grp1_rg_high;
      bg_hi = in_ch.grp1_bg_high;
      lo    = in_ch.grp1_low_bits;
    end else begin
      rg_hi = in_ch.grp2_rg_high;
      bg_hi = in_ch.grp2_bg_high;
      lo    = in_ch.grp2_low_bits;
      grp_ok = (in_ch.group_flag[5:4] == 2'b01);
    end
    item_nxt.rg = {rg_hi, lo[7:6]};
    item_nxt.bg = {bg_hi, lo[5:4]};
    if (in_ch.module_id == a_id) begin
      typ_rg = a_typ_rg;
      typ_bg = a_typ_bg;
    end else begin
      typ_rg = b_typ_rg;
      typ_bg = b_typ_bg;
    end
    item_nxt.num_rg = NUM1_W'(typ_rg * RATIO_SCALE);
    item_nxt.num_bg = NUM1_W'(typ_bg * RATIO_SCALE);
    if (!grp_ok)
      item_nxt.status = ST_NO_GROUP;
    else if (item_nxt.rg == '0 || item_nxt.bg == '0)
      item_nxt.status = ST_ZERO_RATIO;
    else if (in_ch.module_id != a_id && in_ch.module_id != b_id)
      item_nxt.status = ST_UNKNOWN_MODULE;
    else
      item_nxt.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (in_ch.ready) vld_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) item_r <= item_nxt;
  end

endmodule

// ----- design/otp_awb_queue.sv -----
// Short FIFO of classified items between front and back.
// Depends on otp_awb_pkg.
module otp_awb_queue #(
  parameter int unsigned DEPTH = otp_awb_pkg::QUEUE_DEPTH  // power of two
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  otp_awb_pkg::item_t push_item,
  output logic               full,
  input  logic               pop,
  output otp_awb_pkg::item_t pop_item,
  output logic               empty
);
  import otp_awb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_item;
  end

endmodule

// ----- design/otp_awb_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a tag.
// Depends on nothing.
module otp_awb_div #(
  parameter int unsigned NW = 20,
  parameter int unsigned DW = 10,
  parameter int unsigned TW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [NW-1:0] quot,
  output logic [TW-1:0] out_tag
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] den_r [NW];
  logic [TW-1:0] tag_r [NW];
  logic          vld_r [NW];

  genvar s;
  for (s = 0; s < NW; s++) begin : g_stg
    logic [DW-1:0] rem_i, den_i;
    logic [NW-1:0] nq_i;
    logic [TW-1:0] tag_i;
    logic          vld_i;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign nq_i  = num;
      assign den_i = den;
      assign tag_i = tag;
      assign vld_i = in_valid;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign nq_i  = nq_r[s-1];
      assign den_i = den_r[s-1];
      assign tag_i = tag_r[s-1];
      assign vld_i = vld_r[s-1];
    end

    assign trial = {rem_i, nq_i[NW-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else if (en) vld_r[s] <= vld_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
        nq_r[s]  <= {nq_i[NW-2:0], ge};
        den_r[s] <= den_i;
        tag_r[s] <= tag_i;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quot      = nq_r[NW-1];
  assign out_tag   = tag_r[NW-1];

endmodule

// ----- design/otp_awb_back.sv -----
// Back end: ratio divisions, base selection, gain divisions, saturation.
// Depends on otp_awb_pkg, otp_awb_if and otp_awb_div.
module otp_awb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  otp_awb_pkg::item_t q_item,
  output logic               q_pop,
  otp_awb_out_if.source      out_ch
);
  import otp_awb_pkg::*;

  logic                en;
  logic                d1_vld, d1b_vld;
  logic [NUM1_W-1:0]   r_g, b_g;
  logic [2:0]          d1_tag, d1b_tag;
  logic [NUM1_W-1:0]   base_w;
  logic [RATIO_W-1:0]  base;
  status_t             st1;
  logic [NUM2_W-1:0]   num_r, num_g, num_b;
  logic                d2_vld, d2g_vld, d2b_vld;
  logic [NUM2_W-1:0]   q_r, q_g, q_b;
  logic [2:0]          d2_tag, d2g_tag, d2b_tag;
  logic [GAIN_W-1:0]   sat_r, sat_g, sat_b;
  logic                ok2;

  logic              vld_r;
  logic [GAIN_W-1:0] red_r, green_r, blue_r;
  logic              red_ap_r, green_ap_r, blue_ap_r;
  logic [2:0]        status_r;

  // whole pipe advances together unless the output register is held
  assign en    = !vld_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  otp_awb_div #(.NW(NUM1_W), .DW(RATIO_W), .TW(3)) u_div_rg (
    .clk, .rst_n, .en, .in_valid(!q_empty), .num(q_item.num_rg), .den(q_item.rg),
    .tag(q_item.status), .out_valid(d1_vld), .quot(r_g), .out_tag(d1_tag)
  );
  otp_awb_div #(.NW(NUM1_W), .DW(RATIO_W), .TW(3)) u_div_bg (
    .clk, .rst_n, .en, .in_valid(!q_empty), .num(q_item.num_bg), .den(q_item.bg),
    .tag(q_item.status), .out_valid(d1b_vld), .quot(b_g), .out_tag(d1b_tag)
  );

  // base never exceeds 1000, so it fits the ratio width
  always_comb begin
    if (r_g < NUM1_W'(RATIO_SCALE) || b_g < NUM1_W'(RATIO_SCALE))
      base_w = (r_g < b_g) ? r_g : b_g;
    else
      base_w = NUM1_W'(RATIO_SCALE);
    base = base_w[RATIO_W-1:0];
    if (status_t'(d1_tag) != ST_OK) st1 = status_t'(d1_tag);
    else if (base == '0)            st1 = ST_ZERO_BASE;
    else                            st1 = ST_OK;
    num_r = {r_g, 10'b0};
    num_g = NUM2_W'({RATIO_SCALE, 10'b0});
    num_b = {b_g, 10'b0};
  end

  otp_awb_div #(.NW(NUM2_W), .DW(RATIO_W), .TW(3)) u_div_r (
    .clk, .rst_n, .en, .in_valid(d1_vld), .num(num_r), .den(base),
    .tag(st1), .out_valid(d2_vld), .quot(q_r), .out_tag(d2_tag)
  );
  otp_awb_div #(.NW(NUM2_W), .DW(RATIO_W), .TW(3)) u_div_g (
    .clk, .rst_n, .en, .in_valid(d1b_vld), .num(num_g), .den(base),
    .tag(d1b_tag), .out_valid(d2g_vld), .quot(q_g), .out_tag(d2g_tag)
  );
  otp_awb_div #(.NW(NUM2_W), .DW(RATIO_W), .TW(3)) u_div_b (
    .clk, .rst_n, .en, .in_valid(d1_vld), .num(num_b), .den(base),
    .tag(st1), .out_valid(d2b_vld), .quot(q_b), .out_tag(d2b_tag)
  );

  always_comb begin
    sat_r = (|q_r[NUM2_W-1:GAIN_W]) ? '1 : q_r[GAIN_W-1:0];
    sat_g = (|q_g[NUM2_W-1:GAIN_W]) ? '1 : q_g[GAIN_W-1:0];
    sat_b = (|q_b[NUM2_W-1:GAIN_W]) ? '1 : q_b[GAIN_W-1:0];
    ok2   = (status_t'(d2_tag) == ST_OK) && d2g_vld && d2b_vld && (d2g_tag == d2_tag)
            && (d2b_tag == d2_tag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (en) vld_r <= d2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r   <= d2_tag;
      red_r      <= ok2 ? sat_r : '0;
      green_r    <= ok2 ? sat_g : '0;
      blue_r     <= ok2 ? sat_b : '0;
      red_ap_r   <= ok2 && (sat_r > UNITY_GAIN);
      green_ap_r <= ok2 && (sat_g > UNITY_GAIN);
      blue_ap_r  <= ok2 && (sat_b > UNITY_GAIN);
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.red_gain    = red_r;
  assign out_ch.green_gain  = green_r;
  assign out_ch.blue_gain   = blue_r;
  assign out_ch.red_apply   = red_ap_r;
  assign out_ch.green_apply = green_ap_r;
  assign out_ch.blue_apply  = blue_ap_r;
  assign out_ch.status      = status_r;

endmodule

// ----- design/otp_awb_gain_calc.sv -----
// OTP white-balance gain calculator, top level.
// Path from the accepting edge to result valid: front register, queue write,
//   20 ratio divider stages, 30 gain divider stages, output register.
// Throughput: one item per cycle unless out_ch stalls; one quotient bit per stage.
// Reset (rst_n, synchronous): empties front, queue and pipe; registers take defaults.
module otp_awb_gain_calc #(
  parameter int unsigned QUEUE_DEPTH = otp_awb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  otp_awb_in_if.sink     in_ch,
  otp_awb_out_if.source  out_ch,
  otp_awb_cfg_if.sink    cfg_ch
);
  import otp_awb_pkg::*;

  // calibration registers
  logic [7:0] a_id_r, b_id_r;
  logic [9:0] a_typ_rg_r, a_typ_bg_r, b_typ_rg_r, b_typ_bg_r;

  logic  f_valid, q_full, q_empty, q_pop;
  item_t f_item, q_item;

  // writes always land; indexes past the list are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_id_r     <= '0;
      a_typ_rg_r <= RST_A_TYP_RG;
      a_typ_bg_r <= RST_A_TYP_BG;
      b_id_r     <= '0;
      b_typ_rg_r <= RST_B_TYP_RG;
      b_typ_bg_r <= RST_B_TYP_BG;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_A_ID:     a_id_r     <= cfg_ch.data[7:0];
        REG_A_TYP_RG: a_typ_rg_r <= cfg_ch.data[9:0];
        REG_A_TYP_BG: a_typ_bg_r <= cfg_ch.data[9:0];
        REG_B_ID:     b_id_r     <= cfg_ch.data[7:0];
        REG_B_TYP_RG: b_typ_rg_r <= cfg_ch.data[9:0];
        REG_B_TYP_BG: b_typ_bg_r <= cfg_ch.data[9:0];
        default: ;
      endcase
    end
  end

  // front: classify and stage one item
  otp_awb_front u_front (
    .clk, .rst_n, .in_ch,
    .a_id(a_id_r), .a_typ_rg(a_typ_rg_r), .a_typ_bg(a_typ_bg_r),
    .b_id(b_id_r), .b_typ_rg(b_typ_rg_r), .b_typ_bg(b_typ_bg_r),
    .item_valid(f_valid), .item(f_item), .item_ready(!q_full)
  );

  // queue decouples front stalls from back stalls
  otp_awb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(f_valid), .push_item(f_item), .full(q_full),
    .pop(q_pop), .pop_item(q_item), .empty(q_empty)
  );

  // back: divider pipes and output register
  otp_awb_back u_back (
    .clk, .rst_n, .q_empty, .q_item, .q_pop, .out_ch
  );

endmodule

// ----- tb/tb_otp_awb_gain_calc.sv -----
// Testbench for otp_awb_gain_calc: directed and random calibration sets,
// gain prediction in-line, checked item by item at the result channel.
// Depends on otp_awb_pkg, otp_awb_if and the RTL top level.
`timescale 1ns / 100ps
module tb_otp_awb_gain_calc;
  import otp_awb_pkg::*;

  typedef struct packed {
    logic [7:0] flag, r1, b1, l1, r2, b2, l2, id;
  } calib_t;

  typedef struct packed {
    logic [15:0] rg, gg, bg;
    logic        ra, ga, ba;
    logic [2:0]  st;
  } gains_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  otp_awb_in_if  in_ch ();
  otp_awb_out_if out_ch ();
  otp_awb_cfg_if cfg_ch ();

  otp_awb_gain_calc u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the registers
  logic [7:0] a_id, b_id;
  logic [9:0] a_rg, a_bg, b_rg, b_bg;

  calib_t calib_q[$];
  gains_t gains_q[$];
  int     errors = 0;
  bit     no_idle = 1'b0;   // long stretch with no stalls on either side
  bit     hold_tx = 1'b0;   // pauses the sender while draining

  function automatic logic [15:0] norm_gain(longint unsigned ratio, longint unsigned base);
    longint unsigned g;
    g = (64'h400 * ratio) / base;
    return (g > 64'hFFFF) ? 16'hFFFF : g[15:0];
  endfunction

  function automatic gains_t calc_gains(calib_t c);
    gains_t          o;
    logic [7:0]      rh, bh, lo;
    logic [9:0]      rg, bg, trg, tbg;
    longint unsigned r_g, b_g, base;
    o = '0;
    if (c.flag[7:6] == 2'b01) begin
      rh = c.r1; bh = c.b1; lo = c.l1;
    end else if (c.flag[5:4] == 2'b01) begin
      rh = c.r2; bh = c.b2; lo = c.l2;
    end else begin
      o.st = ST_NO_GROUP;
      return o;
    end
    rg = {rh, lo[7:6]};
    bg = {bh, lo[5:4]};
    if (rg == 0 || bg == 0) begin
      o.st = ST_ZERO_RATIO;
      return o;
    end
    // first module wins when both IDs match
    if (c.id == a_id) begin
      trg = a_rg; tbg = a_bg;
    end else if (c.id == b_id) begin
      trg = b_rg; tbg = b_bg;
    end else begin
      o.st = ST_UNKNOWN_MODULE;
      return o;
    end
    r_g = (longint'(trg) * 1000) / rg;
    b_g = (longint'(tbg) * 1000) / bg;
    if (r_g < 1000 || b_g < 1000) base = (r_g < b_g) ? r_g : b_g;
    else base = 1000;
    if (base == 0) begin
      o.st = ST_ZERO_BASE;
      return o;
    end
    o.rg = norm_gain(r_g, base);
    o.gg = norm_gain(1000, base);
    o.bg = norm_gain(b_g, base);
    o.ra = o.rg > UNITY_GAIN;
    o.ga = o.gg > UNITY_GAIN;
    o.ba = o.bg > UNITY_GAIN;
    o.st = ST_OK;
    return o;
  endfunction

  // driver: one item per handshake, random gaps
  calib_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        gains_q.push_back(calc_gains(cur));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (calib_q.size() > 0 && !hold_tx && (no_idle || $urandom_range(99) >= 28)) begin
          cur = calib_q.pop_front();
          in_ch.valid <= 1'b1;
          {in_ch.group_flag, in_ch.grp1_rg_high, in_ch.grp1_bg_high, in_ch.grp1_low_bits,
           in_ch.grp2_rg_high, in_ch.grp2_bg_high, in_ch.grp2_low_bits,
           in_ch.module_id} <= cur;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result with the oldest prediction
  gains_t exp_g;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (gains_q.size() == 0) begin
          $error("result with no prediction pending");
          errors++;
        end else begin
          exp_g = gains_q.pop_front();
          if (out_ch.red_gain !== exp_g.rg) begin
            $error("red_gain exp %0d got %0d", exp_g.rg, out_ch.red_gain); errors++;
          end
          if (out_ch.green_gain !== exp_g.gg) begin
            $error("green_gain exp %0d got %0d", exp_g.gg, out_ch.green_gain); errors++;
          end
          if (out_ch.blue_gain !== exp_g.bg) begin
            $error("blue_gain exp %0d got %0d", exp_g.bg, out_ch.blue_gain); errors++;
          end
          if (out_ch.red_apply !== exp_g.ra) begin
            $error("red_apply exp %0d got %0d", exp_g.ra, out_ch.red_apply); errors++;
          end
          if (out_ch.green_apply !== exp_g.ga) begin
            $error("green_apply exp %0d got %0d", exp_g.ga, out_ch.green_apply); errors++;
          end
          if (out_ch.blue_apply !== exp_g.ba) begin
            $error("blue_apply exp %0d got %0d", exp_g.ba, out_ch.blue_apply); errors++;
          end
          if (out_ch.status !== exp_g.st) begin
            $error("status exp %0d got %0d", exp_g.st, out_ch.status); errors++;
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_A_ID:     a_id = val[7:0];
      REG_A_TYP_RG: a_rg = val[9:0];
      REG_A_TYP_BG: a_bg = val[9:0];
      REG_B_ID:     b_id = val[7:0];
      REG_B_TYP_RG: b_rg = val[9:0];
      REG_B_TYP_BG: b_bg = val[9:0];
      default: ;
    endcase
  endtask

  // wait out everything in flight
  task automatic drain();
    while (calib_q.size() > 0 || in_ch.valid || gains_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(9))
      0, 1, 2, 3: return {2'b01, 6'($urandom)};
      4, 5, 6:    return {2'($urandom_range(3) == 1 ? 0 : $urandom), 2'b01, 4'($urandom)};
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_id();
    case ($urandom_range(4))
      0, 1:    return a_id;
      2, 3:    return b_id;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic calib_t rand_calib();
    calib_t c;
    c = calib_t'({$urandom, $urandom});
    c.flag = pick_flag();
    c.id = pick_id();
    // small typical ratios against big measured ones reach zero base
    if ($urandom_range(9) == 0) begin
      c.r1 = 8'hFF; c.r2 = 8'hFF;
    end
    return c;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) calib_q.push_back(rand_calib());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.group_flag, in_ch.grp1_rg_high, in_ch.grp1_bg_high, in_ch.grp1_low_bits,
     in_ch.grp2_rg_high, in_ch.grp2_bg_high, in_ch.grp2_low_bits, in_ch.module_id} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    a_id = 8'd0; a_rg = RST_A_TYP_RG; a_bg = RST_A_TYP_BG;
    b_id = 8'd0; b_rg = RST_B_TYP_RG; b_bg = RST_B_TYP_BG;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset values first: both IDs are 0, so module A wins
    calib_q.push_back({8'h40, 8'h52, 8'h48, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    calib_q.push_back({8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    calib_q.push_back({8'h50, 8'h00, 8'h00, 8'h00, 8'h4D, 8'h4B, 8'hF0, 8'h00});
    calib_q.push_back({8'h10, 8'h11, 8'h11, 8'h11, 8'h4D, 8'h4B, 8'h30, 8'h00});
    calib_q.push_back({8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00});
    calib_q.push_back({8'h40, 8'h00, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    calib_q.push_back({8'h40, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    calib_q.push_back({8'h40, 8'h00, 8'h00, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00});
    calib_q.push_back({8'h40, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    calib_q.push_back({8'h40, 8'h52, 8'h48, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77});
    drain();

    // small typical ratios: zero base and saturation
    write_reg(REG_A_ID, 16'hFFAA);
    write_reg(REG_A_TYP_RG, 16'd1);
    write_reg(REG_A_TYP_BG, 16'd1023);
    write_reg(REG_B_ID, 16'h0055);
    write_reg(REG_B_TYP_RG, 16'd1023);
    write_reg(REG_B_TYP_BG, 16'hFC01);
    calib_q.push_back({8'h40, 8'hFF, 8'h00, 8'hD0, 8'h00, 8'h00, 8'h00, 8'hAA});
    calib_q.push_back({8'h40, 8'h00, 8'hFF, 8'h40, 8'h00, 8'h00, 8'h00, 8'hAA});
    calib_q.push_back({8'h40, 8'h00, 8'h00, 8'h50, 8'h00, 8'h00, 8'h00, 8'h55});
    calib_q.push_back({8'h40, 8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h55});
    calib_q.push_back({8'h40, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    drain();

    // random phases under several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_A_ID, 16'($urandom)); write_reg(REG_B_ID, 16'($urandom));
        end
        1: begin
          write_reg(REG_A_TYP_RG, 16'd1023); write_reg(REG_A_TYP_BG, 16'd1023);
        end
        2: begin
          write_reg(REG_B_TYP_RG, 16'd1); write_reg(REG_B_TYP_BG, 16'd1);
        end
        3: begin
          write_reg(REG_B_ID, {8'h00, a_id});
          write_reg(REG_A_TYP_RG, 16'(1 + $urandom_range(1022)));
          write_reg(REG_B_TYP_BG, 16'(1 + $urandom_range(1022)));
        end
        default: begin
          write_reg(REG_A_TYP_RG, 16'(1 + $urandom_range(1022)));
          write_reg(REG_A_TYP_BG, 16'(1 + $urandom_range(1022)));
          write_reg(REG_B_TYP_RG, 16'(1 + $urandom_range(1022)));
          write_reg(REG_B_TYP_BG, 16'(1 + $urandom_range(1022)));
          write_reg(REG_A_ID, 16'($urandom)); write_reg(REG_B_ID, 16'($urandom));
        end
      endcase
      no_idle = (ph == 4);
      random_phase(60);
      // sender holds off until every pending result is back
      while (calib_q.size() > 0 || in_ch.valid) @(posedge clk);
      hold_tx = 1'b1;
      while (gains_q.size() > 0) @(posedge clk);
      hold_tx = 1'b0;
      random_phase(55);
      drain();
    end
    no_idle = 1'b0;

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
